>>> design/cosim_pkg.sv
// Package for the cosine similarity block: widths, sequencer codes and control structs.
package cosim_pkg;

   // Sizing of the vectors and elements
   localparam int MAX_LENGTH = 1024;
   localparam int ELEM_W     = 16;
   localparam int FRAC_W     = ELEM_W - 1;
   localparam int LEN_W      = $clog2(MAX_LENGTH);

   // Accumulator and arithmetic widths
   localparam int NORM_W = 2 * ELEM_W - 1 + LEN_W;
   localparam int DOT_W  = NORM_W + 1;
   localparam int ROOT_W = (NORM_W + 1) / 2;
   localparam int DEN_W  = 2 * ROOT_W;
   localparam int MUL_W  = (ROOT_W + 1 > ELEM_W) ? ROOT_W + 1 : ELEM_W;
   localparam int PROD_W = 2 * MUL_W;
   localparam int QUO_W  = ELEM_W;
   localparam int DIV_W  = DOT_W + FRAC_W + 3;
   localparam int CNT_W  = $clog2((ROOT_W > QUO_W) ? ROOT_W : QUO_W);

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_AB,
      ST_MUL_AA,
      ST_MUL_BB,
      ST_ACC_BB,
      ST_SQRT_A,
      ST_SAVE_A,
      ST_SQRT_B,
      ST_MUL_DEN,
      ST_DIV_INIT,
      ST_DIV_OVF,
      ST_DIV_STEP,
      ST_FINISH
   } state_type;

   // Multiplier operand selection
   typedef enum logic [1:0] {
      MUL_AB,
      MUL_AA,
      MUL_BB,
      MUL_DEN
   } mul_sel_type;

   // Accumulator target for the registered product
   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_DOT,
      ACC_NA,
      ACC_NB
   } acc_sel_type;

   // Sequencer to datapath
   typedef struct packed {
      logic        take;
      mul_sel_type mul_sel;
      acc_sel_type acc_sel;
      logic        sqrt_init_a;
      logic        sqrt_init_b;
      logic        sqrt_step;
      logic        div_init;
      logic        div_ovf;
      logic        div_step;
      logic        finish;
   } ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic cs_ge;
      logic zero_den;
   } stat_type;

endpackage

>>> design/cosim_if.sv
// Valid/ready channel interfaces for element pairs and similarity results.
interface cosim_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cosim_pkg::ELEM_W-1:0]  elem_a;
   logic signed [cosim_pkg::ELEM_W-1:0]  elem_b;
   logic                                 present;
   logic                                 last;

   modport source (output valid, output elem_a, output elem_b, output present,
                   output last, input ready);
   modport sink   (input valid, input elem_a, input elem_b, input present,
                   input last, output ready);
endinterface

interface cosim_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cosim_pkg::ELEM_W-1:0]  similarity;
   logic                                 zero_denominator;

   modport source (output valid, output similarity, output zero_denominator,
                   input ready);
   modport sink   (input valid, input similarity, input zero_denominator,
                   output ready);
endinterface

>>> design/cosim_cmpsub.sv
// Shared compare-and-subtract unit used by the square root and divide steps.
module cosim_cmpsub (
   input  logic [cosim_pkg::DIV_W-1:0] op_a,
   input  logic [cosim_pkg::DIV_W-1:0] op_b,
   output logic                        ge,
   output logic [cosim_pkg::DIV_W-1:0] diff
);
   import cosim_pkg::*;

   logic [DIV_W:0] wide_diff;

   // One wide subtract; the borrow gives the compare
   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign ge        = ~wide_diff[DIV_W];
   assign diff      = wide_diff[DIV_W-1:0];
endmodule

>>> design/cosim_datapath.sv
// Datapath: multiplier, saturating accumulators, square root and divide registers.
module cosim_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  cosim_pkg::ctrl_type                 ctrl,
   input  logic signed [cosim_pkg::ELEM_W-1:0] elem_a,
   input  logic signed [cosim_pkg::ELEM_W-1:0] elem_b,
   output cosim_pkg::stat_type                 stat,
   output logic signed [cosim_pkg::ELEM_W-1:0] sim,
   output logic                                zden
);
   import cosim_pkg::*;

   localparam logic signed [DOT_W:0] DOT_MAX = {2'b00, {(DOT_W-1){1'b1}}};
   localparam logic signed [DOT_W:0] DOT_MIN = {2'b11, {(DOT_W-1){1'b0}}};
   localparam logic [NORM_W-1:0] BIT_INIT = NORM_W'(1) << (2 * (ROOT_W - 1));
   localparam logic [QUO_W-1:0] POS_LIM = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic [QUO_W-1:0] NEG_LIM = {1'b1, {(QUO_W-1){1'b0}}};

   logic signed [ELEM_W-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic [NORM_W-1:0]        na_ff, na_in, nb_ff, nb_in;
   logic                     seen_ff, seen_in;
   logic [NORM_W-1:0]        x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic [ROOT_W-1:0]        sqa_ff, sqa_in;
   logic [DIV_W-1:0]         rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic                     zden_ff, zden_in, sat_ff, sat_in;

   logic signed [MUL_W-1:0]  op_x, op_y;
   logic signed [DOT_W:0]    dot_sum;
   logic [NORM_W:0]          norm_sum, norm_acc;
   logic [NORM_W:0]          sq_trial;
   logic [DIV_W-1:0]         cs_a, cs_b, cs_diff;
   logic                     cs_ge;
   logic [DEN_W-1:0]         den;
   logic [DOT_W-1:0]         mag;
   logic                     neg;

   cosim_cmpsub u_cmpsub (
      .op_a (cs_a),
      .op_b (cs_b),
      .ge   (cs_ge),
      .diff (cs_diff)
   );

   // Multiplier operand select
   always_comb begin
      op_x = MUL_W'(a_ff);
      op_y = MUL_W'(b_ff);
      case (ctrl.mul_sel)
         MUL_AB: begin
            op_x = MUL_W'(a_ff);
            op_y = MUL_W'(b_ff);
         end
         MUL_AA: begin
            op_x = MUL_W'(a_ff);
            op_y = MUL_W'(a_ff);
         end
         MUL_BB: begin
            op_x = MUL_W'(b_ff);
            op_y = MUL_W'(b_ff);
         end
         MUL_DEN: begin
            op_x = signed'({{(MUL_W-ROOT_W){1'b0}}, sqa_ff});
            op_y = signed'({{(MUL_W-ROOT_W){1'b0}}, res_ff[ROOT_W-1:0]});
         end
         default: begin
            op_x = MUL_W'(a_ff);
            op_y = MUL_W'(b_ff);
         end
      endcase
   end

   assign prod_in = op_x * op_y;

   // Saturating sums of the registered product (dot sum is signed on both sides)
   assign dot_sum = (DOT_W+1)'(dot_ff) + signed'(prod_ff[DOT_W:0]);
   always_comb begin
      norm_acc = {1'b0, na_ff};
      if (ctrl.acc_sel == ACC_NB) begin
         norm_acc = {1'b0, nb_ff};
      end
      norm_sum = norm_acc + prod_ff[NORM_W:0];
   end

   // Compare-subtract operands: square root trial or divide remainder
   assign sq_trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign cs_a     = ctrl.sqrt_step ? DIV_W'(x_ff) : rem_ff;
   assign cs_b     = ctrl.sqrt_step ? DIV_W'(sq_trial) : dsh_ff;

   assign den  = prod_ff[DEN_W-1:0];
   assign neg  = dot_ff[DOT_W-1];
   assign mag  = neg ? DOT_W'(-dot_ff) : DOT_W'(dot_ff);

   assign stat.cs_ge    = cs_ge;
   assign stat.zero_den = ~seen_ff | (den == '0);

   // Next-state logic for the datapath registers other than the product
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      dot_in  = dot_ff;
      na_in   = na_ff;
      nb_in   = nb_ff;
      seen_in = seen_ff;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      sqa_in  = sqa_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      zden_in = zden_ff;
      sat_in  = sat_ff;

      if (ctrl.take) begin
         a_in = elem_a;
         b_in = elem_b;
      end

      // accumulate with saturation
      case (ctrl.acc_sel)
         ACC_DOT: begin
            seen_in = 1'b1;
            if (dot_sum > DOT_MAX) begin
               dot_in = DOT_MAX[DOT_W-1:0];
            end else if (dot_sum < DOT_MIN) begin
               dot_in = DOT_MIN[DOT_W-1:0];
            end else begin
               dot_in = dot_sum[DOT_W-1:0];
            end
         end
         ACC_NA: na_in = norm_sum[NORM_W] ? '1 : norm_sum[NORM_W-1:0];
         ACC_NB: nb_in = norm_sum[NORM_W] ? '1 : norm_sum[NORM_W-1:0];
         default: ;
      endcase

      // square root: start, one digit per step
      if (ctrl.sqrt_init_a) begin
         x_in   = na_ff;
         res_in = '0;
         bit_in = BIT_INIT;
      end
      if (ctrl.sqrt_init_b) begin
         sqa_in = res_ff[ROOT_W-1:0];
         x_in   = nb_ff;
         res_in = '0;
         bit_in = BIT_INIT;
      end
      if (ctrl.sqrt_step) begin
         if (cs_ge) begin
            x_in   = cs_diff[NORM_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end

      // rounded divide: dividend 2*mag*2^F + den, divisor 2*den
      if (ctrl.div_init) begin
         zden_in = stat.zero_den;
         rem_in  = (DIV_W'(mag) << (FRAC_W + 1)) + DIV_W'(den);
         dsh_in  = DIV_W'(den) << (QUO_W + 1);
         quo_in  = '0;
      end
      if (ctrl.div_ovf) begin
         sat_in = cs_ge;
         dsh_in = dsh_ff >> 1;
      end
      if (ctrl.div_step) begin
         if (cs_ge) begin
            rem_in = cs_diff;
         end
         quo_in = {quo_ff[QUO_W-2:0], cs_ge};
         dsh_in = dsh_ff >> 1;
      end

      // clear for the next vector pair
      if (ctrl.finish) begin
         dot_in  = '0;
         na_in   = '0;
         nb_in   = '0;
         seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= '0;
         na_ff   <= '0;
         nb_ff   <= '0;
         seen_ff <= 1'b0;
      end else begin
         dot_ff  <= dot_in;
         na_ff   <= na_in;
         nb_ff   <= nb_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      x_ff    <= x_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      sqa_ff  <= sqa_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      zden_ff <= zden_in;
      sat_ff  <= sat_in;
   end

   // Final sign, saturation and zero cases
   always_comb begin
      zden = zden_ff;
      if (zden_ff) begin
         sim = '0;
      end else if (neg) begin
         sim = (sat_ff || quo_ff > NEG_LIM) ? signed'(NEG_LIM) : signed'(-quo_ff);
      end else begin
         sim = (sat_ff || quo_ff > POS_LIM) ? signed'(POS_LIM) : signed'(quo_ff);
      end
   end
endmodule

>>> design/cosim_ctrl.sv
// Sequencer: steps the shared multiplier and compare-subtract unit through each item.
module cosim_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_present,
   input  logic                req_last,
   input  logic                out_busy,
   input  cosim_pkg::stat_type stat,
   output logic                req_ready,
   output cosim_pkg::ctrl_type ctrl
);
   import cosim_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last_ff, last_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

   // Next state and control strobes
   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      last_in          = last_ff;
      ctrl             = '0;
      ctrl.mul_sel     = MUL_DEN;
      ctrl.acc_sel     = ACC_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.take = 1'b1;
               last_in   = req_last;
               if (req_present) begin
                  state_in = ST_MUL_AB;
               end else if (req_last) begin
                  ctrl.sqrt_init_a = 1'b1;
                  cnt_in           = '0;
                  state_in         = ST_SQRT_A;
               end
            end
         end
         ST_MUL_AB: begin
            ctrl.mul_sel = MUL_AB;
            state_in     = ST_MUL_AA;
         end
         ST_MUL_AA: begin
            ctrl.mul_sel = MUL_AA;
            ctrl.acc_sel = ACC_DOT;
            state_in     = ST_MUL_BB;
         end
         ST_MUL_BB: begin
            ctrl.mul_sel = MUL_BB;
            ctrl.acc_sel = ACC_NA;
            state_in     = ST_ACC_BB;
         end
         ST_ACC_BB: begin
            ctrl.acc_sel = ACC_NB;
            if (last_ff) begin
               ctrl.sqrt_init_a = 1'b1;
               cnt_in           = '0;
               state_in         = ST_SQRT_A;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SQRT_A: begin
            ctrl.sqrt_step = 1'b1;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               state_in = ST_SAVE_A;
            end
         end
         ST_SAVE_A: begin
            ctrl.sqrt_init_b = 1'b1;
            cnt_in           = '0;
            state_in         = ST_SQRT_B;
         end
         ST_SQRT_B: begin
            ctrl.sqrt_step = 1'b1;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               state_in = ST_MUL_DEN;
            end
         end
         ST_MUL_DEN: begin
            ctrl.mul_sel = MUL_DEN;
            state_in     = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            ctrl.div_init = 1'b1;
            state_in      = stat.zero_den ? ST_FINISH : ST_DIV_OVF;
         end
         ST_DIV_OVF: begin
            ctrl.div_ovf = 1'b1;
            cnt_in       = '0;
            state_in     = stat.cs_ge ? ST_FINISH : ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            ctrl.div_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_busy) begin
               ctrl.finish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

>>> design/cosine_similarity.sv
// Top level of the streaming cosine similarity block.
// Element pairs (signed Q1.15) arrive one transaction at a time; after a pair is
// accepted the input stays busy until its products are accumulated, because one
// 22x22 multiplier forms a*b, a*a and b*b in turn and feeds the saturating
// accumulators. A transaction without a pair and not marked last frees the input
// at once. On the transaction marked last the block then runs on one shared
// compare-subtract unit: two 21-step integer square roots of the norms, their
// product on the multiplier, and a 16-step restoring divide with round-half-away
// rounding and saturation to Q1.15. The result sits in an output register, so a new
// vector pair may start while it waits; a further result waits until that register
// is free. An empty vector or a zero norm gives similarity 0 with zero_denominator
// set. The block needs no clearing pass after reset.
module cosine_similarity (
   input logic         clock,
   input logic         reset,
   cosim_req_if.sink   req_chan,
   cosim_rsp_if.source rsp_chan
);
   import cosim_pkg::*;

   ctrl_type                 ctrl;
   stat_type                 stat;
   logic                     req_ready;
   logic                     out_busy;
   logic signed [ELEM_W-1:0] sim;
   logic                     zden;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ELEM_W-1:0] rsp_sim_ff, rsp_sim_in;
   logic                     rsp_zden_ff, rsp_zden_in;

   cosim_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_present (req_chan.present),
      .req_last    (req_chan.last),
      .out_busy    (out_busy),
      .stat        (stat),
      .req_ready   (req_ready),
      .ctrl        (ctrl)
   );

   cosim_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .elem_a (req_chan.elem_a),
      .elem_b (req_chan.elem_b),
      .stat   (stat),
      .sim    (sim),
      .zden   (zden)
   );

   assign req_chan.ready = req_ready;
   assign out_busy       = rsp_valid_ff & ~rsp_chan.ready;

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_sim_in   = rsp_sim_ff;
      rsp_zden_in  = rsp_zden_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_sim_in   = sim;
         rsp_zden_in  = zden;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sim_ff  <= rsp_sim_in;
      rsp_zden_ff <= rsp_zden_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.similarity       = rsp_sim_ff;
   assign rsp_chan.zero_denominator = rsp_zden_ff;

   // A result is loaded only into a free output slot
   assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result loaded over a pending response");

   // A transaction with no pair and no last mark frees the input at once
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !req_chan.present && !req_chan.last)
      |=> req_chan.ready)
      else $error("input not ready after an empty transaction");

   // A zero denominator always comes with a zero similarity
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_zden_ff) |-> (rsp_sim_ff == '0))
      else $error("nonzero similarity with zero denominator");

   // The sequencer is back in idle right after a result
   assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> req_chan.ready)
      else $error("sequencer did not return to idle after a result");
endmodule

>>> tb/cosine_similarity_tb.sv
// Self-checking testbench for the streaming cosine similarity block.
`timescale 1ns / 100ps

module cosine_similarity_tb;

   import cosim_pkg::*;

   typedef logic signed [ELEM_W-1:0] elem_type;

   // One similarity transaction as it should leave the block
   typedef struct {
      elem_type similarity;
      logic     zero_denominator;
   } sim_result_type;

   localparam longint          DOT_HI       = (64'sd1 <<< (DOT_W - 1)) - 1;
   localparam longint          DOT_LO       = -DOT_HI - 1;
   localparam longint unsigned NORM_HI      = (64'd1 << NORM_W) - 1;
   localparam int              STALL_LIMIT  = 2000;
   localparam int              HOLD_CYCLES  = 300;
   localparam int              DRAIN_CYCLES = 100;
   localparam int              RANDOM_ITEMS = 580;

   logic clock;
   logic reset;

   cosim_req_if req_bus ();
   cosim_rsp_if rsp_bus ();

   cosine_similarity dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predictor state: running sums of the current vector pair
   longint          dot_acc;
   longint unsigned norm_a_acc;
   longint unsigned norm_b_acc;
   bit              any_pair;

   sim_result_type expected_sims[$];
   int             mismatch_count;
   bit             sender_idle_on;
   bit             rsp_idle_on;
   int             rsp_wait;
   int             hold_left;
   bit             hold_request;
   int             quiet_cycles;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor of the square root, one result bit at a time
   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   // Accumulate one accepted transaction; on last, queue the expected similarity
   task automatic cosine_predict(elem_type a, elem_type b, bit present, bit last);
      longint          dsum;
      longint unsigned sq_a;
      longint unsigned sq_b;
      longint unsigned den;
      longint unsigned mag;
      longint unsigned q;
      sim_result_type  r;
      if (present) begin
         dsum = dot_acc + longint'(a) * longint'(b);
         if (dsum > DOT_HI) dsum = DOT_HI;
         if (dsum < DOT_LO) dsum = DOT_LO;
         dot_acc = dsum;
         sq_a = longint'(a) * longint'(a);
         sq_b = longint'(b) * longint'(b);
         norm_a_acc = (norm_a_acc + sq_a > NORM_HI) ? NORM_HI : norm_a_acc + sq_a;
         norm_b_acc = (norm_b_acc + sq_b > NORM_HI) ? NORM_HI : norm_b_acc + sq_b;
         any_pair = 1'b1;
      end
      if (!last) return;
      den = floor_sqrt(norm_a_acc) * floor_sqrt(norm_b_acc);
      r.similarity = '0;
      r.zero_denominator = 1'b1;
      if (any_pair && den != 0) begin
         mag = (dot_acc < 0) ? -dot_acc : dot_acc;
         // round half away from zero on the magnitude
         q = (2 * (mag << FRAC_W) + den) / (2 * den);
         if (dot_acc < 0)
            r.similarity = (q > 32768) ? elem_type'(-32768) : elem_type'(-longint'(q));
         else
            r.similarity = (q > 32767) ? elem_type'(32767) : elem_type'(q);
         r.zero_denominator = 1'b0;
      end
      expected_sims.push_back(r);
      dot_acc = 0;
      norm_a_acc = 0;
      norm_b_acc = 0;
      any_pair = 1'b0;
   endtask

   // Offer one element transaction; entered and left at a falling edge
   task automatic send_item(elem_type a, elem_type b, bit present, bit last);
      int gap;
      gap = sender_idle_on ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.elem_a  <= a;
      req_bus.elem_b  <= b;
      req_bus.present <= present;
      req_bus.last    <= last;
      do @(posedge clock); while (!req_bus.ready);
      cosine_predict(a, b, present, last);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected similarity has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_sims.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic elem_type rand_elem(int style);
      case (style)
         0: return elem_type'($urandom);
         1: return elem_type'(int'($urandom_range(0, 511)) - 256);
         default: begin
            case ($urandom_range(0, 4))
               0: return elem_type'(-32768);
               1: return elem_type'(32767);
               2: return elem_type'(0);
               3: return elem_type'(1);
               default: return elem_type'(-1);
            endcase
         end
      endcase
   endfunction

   // Extremes of the elements and each corner of the result path
   task automatic test_edge_vectors();
      sender_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      // empty vector pair
      send_item(elem_type'($urandom), elem_type'($urandom), 1'b0, 1'b1);
      // ratio at or above one, both signs
      send_item(-16'sd32768, -16'sd32768, 1'b1, 1'b1);
      send_item(16'sd32767, 16'sd32767, 1'b1, 1'b1);
      send_item(16'sd1, -16'sd1, 1'b1, 1'b1);
      send_item(-16'sd32768, 16'sd32767, 1'b1, 1'b1);
      // all-zero elements
      send_item(16'sd0, 16'sd0, 1'b1, 1'b0);
      send_item(16'sd0, 16'sd0, 1'b1, 1'b1);
      // one norm zero
      send_item(16'sd0, 16'sd1234, 1'b1, 1'b0);
      send_item(16'sd0, -16'sd5, 1'b1, 1'b1);
      send_item(16'sd7, 16'sd0, 1'b1, 1'b1);
      // items without a pair, inside and at the end
      send_item(16'sd100, 16'sd200, 1'b1, 1'b0);
      send_item(elem_type'($urandom), elem_type'($urandom), 1'b0, 1'b0);
      send_item(-16'sd300, 16'sd50, 1'b1, 1'b0);
      send_item(elem_type'($urandom), elem_type'($urandom), 1'b0, 1'b1);
      // alternating bit patterns
      send_item(16'sh5555, elem_type'(16'hAAAA), 1'b1, 1'b0);
      send_item(elem_type'(16'hAAAA), 16'sh5555, 1'b1, 1'b1);
      // orthogonal vectors
      send_item(16'sd16384, 16'sd0, 1'b1, 1'b0);
      send_item(16'sd0, 16'sd16384, 1'b1, 1'b1);
      // empty vector of two items
      send_item(elem_type'($urandom), elem_type'($urandom), 1'b0, 1'b0);
      send_item(elem_type'($urandom), elem_type'($urandom), 1'b0, 1'b1);
      drain_results();
   endtask

   // Full-length vector of extreme elements, driving the sums toward their largest
   task automatic test_full_length_vector();
      sender_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int i = 0; i < MAX_LENGTH; i++)
         send_item(rand_elem(2), rand_elem(2), 1'b1, i == MAX_LENGTH - 1);
      drain_results();
   endtask

   // Receiver holds off long enough for the block to stall its input
   task automatic test_output_backpressure();
      int len;
      sender_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      @(posedge clock);
      hold_request = 1'b1;
      @(negedge clock);
      for (int v = 0; v < 8; v++) begin
         len = $urandom_range(1, 3);
         for (int i = 0; i < len; i++)
            send_item(rand_elem(0), rand_elem(0), 1'b1, i == len - 1);
      end
      drain_results();
   endtask

   // Random vector pairs, mostly well formed, some with correlated content
   task automatic test_random_vectors();
      int       items;
      int       len;
      int       style;
      elem_type a;
      elem_type b;
      bit       present;
      items = 0;
      while (items < RANDOM_ITEMS) begin
         sender_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         style = $urandom_range(0, 5);
         for (int i = 0; i < len; i++) begin
            a = rand_elem((style == 4) ? 1 : (style == 5) ? 2 : 0);
            case (style)
               2: b = $urandom_range(0, 1) ? a : -a;
               3: b = a + rand_elem(1);
               4: b = rand_elem(1);
               5: b = rand_elem(2);
               default: b = rand_elem(0);
            endcase
            present = ($urandom_range(0, 7) != 0);
            send_item(a, b, present, i == len - 1);
            items++;
         end
      end
      drain_results();
   endtask

   // Receiver: ready with random stalls, plus the long hold when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each similarity transaction with the oldest expectation
   always @(posedge clock) begin
      sim_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_sims.size() == 0) begin
            $display("%0t: unexpected result: similarity %0d zero_denominator %0b",
                     $time, rsp_bus.similarity, rsp_bus.zero_denominator);
            mismatch_count++;
         end else begin
            want = expected_sims.pop_front();
            if (rsp_bus.similarity !== want.similarity) begin
               $display("%0t: similarity mismatch: expected %0d, actual %0d",
                        $time, want.similarity, rsp_bus.similarity);
               mismatch_count++;
            end
            if (rsp_bus.zero_denominator !== want.zero_denominator) begin
               $display("%0t: zero_denominator mismatch: expected %0b, actual %0b",
                        $time, want.zero_denominator, rsp_bus.zero_denominator);
               mismatch_count++;
            end
         end
         rsp_wait = rsp_idle_on ? $urandom_range(0, 4) : 0;
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Sequence of tests
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.elem_a = '0;
      req_bus.elem_b = '0;
      req_bus.present = 1'b0;
      req_bus.last = 1'b0;
      rsp_bus.ready = 1'b0;
      dot_acc = 0;
      norm_a_acc = 0;
      norm_b_acc = 0;
      any_pair = 1'b0;
      mismatch_count = 0;
      sender_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      rsp_wait = 0;
      hold_left = 0;
      hold_request = 1'b0;
      quiet_cycles = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_edge_vectors();
      test_output_backpressure();
      test_full_length_vector();
      test_random_vectors();

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> filelist.f
design/cosim_pkg.sv
design/cosim_if.sv
design/cosim_cmpsub.sv
design/cosim_datapath.sv
design/cosim_ctrl.sv
design/cosine_similarity.sv
tb/cosine_similarity_tb.sv
